// ----- hw/rtl/itpm_pkg.sv -----
package itpm_pkg;

    // fixed design constants
    localparam int unsigned TARGET_LIMIT           = 32000;
    localparam int unsigned INITIAL_TARGET         = 800;
    localparam bit          INHIBIT_START_INPUT    = 1'b0;
    localparam int unsigned FIXED_START_TARGET     = 800;
    localparam logic [7:0]  AUTOMATIC_GEARBOX_CODE = 8'd1;
    localparam bit          IGNORE_IDLE_INIT       = 1'b0;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_INCREMENT    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CAP        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE_OFFSET  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXCESS_DELAY_RAW  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DYNAMIC_OFFSET    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_THRESHOLD   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_LIMIT    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_DELAY    = 4'd7;

    typedef struct packed {
        logic [15:0] start_target;
        logic        torque_active;
        logic [7:0]  gearbox_code;
        logic [15:0] automatic_target;
        logic [15:0] safety_target;
        logic [15:0] unchecked_target;
        logic [15:0] dynamic_target;
        logic [15:0] takeoff_offset;
        logic [15:0] engine_speed;
        logic        idle_init;
    } in_item_t;

    typedef struct packed {
        logic        fault;
        logic [14:0] tolerance_limit;
        logic [14:0] limited_reference;
        logic        dynamic_monitor_on;
    } out_item_t;

endpackage

// ----- hw/rtl/idle_target_plausibility_monitor_top.sv -----
// Idle target plausibility monitor: one input transfer per control tick gives one result
// transfer. A tick is captured in an input register, evaluated by a short adder, compare and
// min/max path, and lands in a result register when that register is free or being taken, so
// ticks can be taken every cycle while out_ready keeps up (one tick per cycle sustained). The
// tick-to-tick state (reference target, debounce counters, previous dynamic target) is
// updated as a tick moves into the result register. Configuration writes take effect at once
// and are meant for idle periods; writes to indexes beyond the register list are dropped.
module idle_target_plausibility_monitor_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  itpm_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output itpm_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [itpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);

    localparam logic [14:0] LIMIT15 = 15'(itpm_pkg::TARGET_LIMIT);
    localparam logic [15:0] INIT16  = 16'(itpm_pkg::INITIAL_TARGET);
    localparam logic [15:0] FIXED16 = 16'(itpm_pkg::FIXED_START_TARGET);
    localparam logic [14:0] INIT_REF =
        (INIT16 < {1'b0, LIMIT15}) ? INIT16[14:0] : LIMIT15;
    localparam logic [14:0] FIXED_START =
        (FIXED16 < {1'b0, LIMIT15}) ? FIXED16[14:0] : LIMIT15;

    // configuration registers
    logic [15:0]        rate_increment_reg;
    logic [15:0]        target_cap_reg;
    logic [15:0]        tolerance_offset_reg;
    logic [15:0]        excess_delay_raw_reg;
    logic [15:0]        dynamic_offset_reg;
    logic [15:0]        speed_threshold_reg;
    logic signed [15:0] gradient_limit_reg;
    logic [7:0]         gradient_delay_raw_reg;

    // pipeline registers
    logic                 stage_valid_reg;
    itpm_pkg::in_item_t   stage_reg;
    logic                 out_valid_reg;
    itpm_pkg::out_item_t  out_reg;

    // tick-to-tick state
    logic        torque_before_reg;
    logic [14:0] reference_reg;
    logic [14:0] excess_count_reg;
    logic [8:0]  gradient_count_reg;
    logic [14:0] dynamic_before_reg;

    logic                advance;
    logic [14:0]         start_value;
    logic [14:0]         base_value;
    logic [16:0]         step_sum;
    logic [15:0]         stepped;
    logic [14:0]         reference_next;
    logic [15:0]         floor_value;
    logic [15:0]         tol_raised;
    logic [15:0]         tol_capped;
    logic [16:0]         tol_sum;
    logic [14:0]         tolerance;
    logic [16:0]         delay1_sum;
    logic [14:0]         delay1;
    logic [14:0]         excess_min;
    logic [14:0]         excess_count_next;
    logic                turn1;
    logic signed [16:0]  rise;
    logic signed [16:0]  limit_ext;
    logic [17:0]         dyn_offset_sum;
    logic [17:0]         speed_x4;
    logic                monitor_on;
    logic                gradient_hit;
    logic [8:0]          delay2;
    logic [8:0]          gradient_min;
    logic [8:0]          gradient_count_next;
    logic                turn2;
    logic [14:0]         dynamic_before_next;
    itpm_pkg::out_item_t out_next;

    // handshake: the stage moves on when the result register is free or being taken
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // rate-limited reference
    always_comb
    begin
        if (itpm_pkg::INHIBIT_START_INPUT)
            start_value = FIXED_START;
        else if (stage_reg.start_target < {1'b0, LIMIT15})
            start_value = stage_reg.start_target[14:0];
        else
            start_value = LIMIT15;

        base_value = (stage_reg.torque_active && !torque_before_reg) ? start_value
                                                                     : reference_reg;
        step_sum = {1'b0, rate_increment_reg} + {2'b0, base_value};
        stepped  = (step_sum < {1'b0, stage_reg.safety_target}) ? step_sum[15:0]
                                                                 : stage_reg.safety_target;
        reference_next = (stepped < {1'b0, LIMIT15}) ? stepped[14:0] : LIMIT15;
    end

    // tolerance limit
    always_comb
    begin
        floor_value = (stage_reg.gearbox_code == itpm_pkg::AUTOMATIC_GEARBOX_CODE)
                      ? stage_reg.automatic_target : 16'd0;
        tol_raised  = (floor_value > stepped) ? floor_value : stepped;
        tol_capped  = (tol_raised < target_cap_reg) ? tol_raised : target_cap_reg;
        tol_sum     = {1'b0, tol_capped} + {1'b0, tolerance_offset_reg};
        tolerance   = (tol_sum < {2'b0, LIMIT15}) ? tol_sum[14:0] : LIMIT15;
    end

    // excess check debounce
    always_comb
    begin
        delay1_sum = {1'b0, excess_delay_raw_reg} + 17'd6;
        delay1     = delay1_sum[16:2];
        excess_min = (delay1 < excess_count_reg) ? delay1 : excess_count_reg;
        if (stage_reg.unchecked_target <= {1'b0, tolerance})
            excess_count_next = '0;
        else
            excess_count_next = excess_min + 15'd1;
        turn1 = excess_count_next >= delay1;
    end

    // dynamic gradient check and debounce
    always_comb
    begin
        rise      = $signed({1'b0, stage_reg.dynamic_target})
                  - $signed({2'b0, dynamic_before_reg});
        limit_ext = {gradient_limit_reg[15], gradient_limit_reg};
        dyn_offset_sum = {2'b0, dynamic_offset_reg} + {2'b0, stage_reg.unchecked_target}
                       + {2'b0, stage_reg.takeoff_offset};
        speed_x4   = {stage_reg.engine_speed, 2'b00};
        monitor_on = ({2'b0, stage_reg.dynamic_target} > dyn_offset_sum)
                  && (speed_x4 > {2'b0, speed_threshold_reg})
                  && (itpm_pkg::IGNORE_IDLE_INIT || !stage_reg.idle_init);
        gradient_hit = monitor_on && (rise > limit_ext);

        delay2       = {1'b0, gradient_delay_raw_reg} + 9'd1;
        gradient_min = (gradient_count_reg < delay2) ? gradient_count_reg : delay2;
        gradient_count_next = gradient_hit ? (gradient_min + 9'd1) : 9'd0;
        turn2 = gradient_count_next >= delay2;

        dynamic_before_next = (stage_reg.dynamic_target < {1'b0, LIMIT15})
                              ? stage_reg.dynamic_target[14:0] : LIMIT15;
    end

    // result assembly
    always_comb
    begin
        out_next.fault              = turn1 || turn2;
        out_next.tolerance_limit    = tolerance;
        out_next.limited_reference  = reference_next;
        out_next.dynamic_monitor_on = monitor_on;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_increment_reg     <= 16'd10;
            target_cap_reg         <= 16'd32000;
            tolerance_offset_reg   <= 16'd100;
            excess_delay_raw_reg   <= 16'd40;
            dynamic_offset_reg     <= 16'd0;
            speed_threshold_reg    <= 16'd0;
            gradient_limit_reg     <= 16'sd50;
            gradient_delay_raw_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                itpm_pkg::REG_RATE_INCREMENT:   rate_increment_reg     <= cfg_data;
                itpm_pkg::REG_TARGET_CAP:       target_cap_reg         <= cfg_data;
                itpm_pkg::REG_TOLERANCE_OFFSET: tolerance_offset_reg   <= cfg_data;
                itpm_pkg::REG_EXCESS_DELAY_RAW: excess_delay_raw_reg   <= cfg_data;
                itpm_pkg::REG_DYNAMIC_OFFSET:   dynamic_offset_reg     <= cfg_data;
                itpm_pkg::REG_SPEED_THRESHOLD:  speed_threshold_reg    <= cfg_data;
                itpm_pkg::REG_GRADIENT_LIMIT:   gradient_limit_reg     <= $signed(cfg_data);
                itpm_pkg::REG_GRADIENT_DELAY:   gradient_delay_raw_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
            torque_before_reg  <= 1'b0;
            reference_reg      <= INIT_REF;
            excess_count_reg   <= '0;
            gradient_count_reg <= '0;
            dynamic_before_reg <= '0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                torque_before_reg  <= stage_reg.torque_active;
                reference_reg      <= reference_next;
                excess_count_reg   <= excess_count_next;
                gradient_count_reg <= gradient_count_next;
                dynamic_before_reg <= dynamic_before_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_reg <= in_data;
        if (advance)
            out_reg <= out_next;
    end

endmodule
